/* hw/rtl/b2bcd_pkg.sv */
// Shared types, constants and the shift-and-add-3 step of the BCD converter.
`default_nettype none
package b2bcd_pkg;

  localparam int VALUE_W         = 16;
  localparam int DIGIT_W         = 4;
  localparam int OUT_DIGITS      = 5;
  localparam int BCD_W           = OUT_DIGITS * DIGIT_W;
  localparam int CNT_W           = 3;
  localparam int STEPS_PER_STAGE = 4;
  localparam int NUM_STAGES      = VALUE_W / STEPS_PER_STAGE;

  localparam logic [DIGIT_W-1:0] BLANK_CODE = 4'd15;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;

  // Register index of the digit count register.
  localparam logic REG_DIGIT_COUNT = 1'b0;

  // One item as it moves through the converter.
  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
    logic [CNT_W-1:0]   cnt;
    logic               ovf;
  } work_t;

  // One double-dabble step: correct every BCD digit of five or more by
  // adding three, then shift the whole word left by one bit.
  function automatic work_t dabble_step(input work_t w);
    work_t r;
    logic [BCD_W-1:0] adj;
    r   = w;
    adj = w.bcd;
    for (int k = 0; k < OUT_DIGITS; k++) begin
      if (adj[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adj[k*DIGIT_W +: DIGIT_W] = adj[k*DIGIT_W +: DIGIT_W] + 4'd3;
      end
    end
    r.bcd = {adj[BCD_W-2:0], w.bin[VALUE_W-1]};
    r.bin = {w.bin[VALUE_W-2:0], 1'b0};
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/binary_to_bcd_blanked_unit.sv */
// Top level of the 16-bit binary to blanked decimal display converter.
//
// Usage: an unsigned 16-bit value enters on the in_ stream channel and one
// item per value leaves on the out_ channel, holding five display digits
// (most significant position in the lowest bits of out_tdata) and an
// overflow flag in out_tuser. A digit is 0-9 or 15 for blank. Leading zeros
// are blanked except in the last used position, and positions beyond the
// digit count are blank. A value that does not fit the digit count sets
// overflow and shows nines in every used position.
// The digit count is written through the cfg_ APB port (register 0, byte
// address 0); the user must write it only while the block is idle, as the
// block does not enforce this. It resets to 5 and is clamped to
// 2..MAX_DIGITS when used. Each item passes four double-dabble stages of
// four shift-and-add-3 steps each, then the formatting stage that is also the
// output register. Throughput is one item per cycle while out_tready is high.
// Reset empties every stage. When the receiver stalls, each stage holds its
// item and empty stages ahead of it still fill, so the input keeps flowing
// until the pipeline is full; nothing is dropped or repeated.
`default_nettype none
module binary_to_bcd_blanked_unit
  import b2bcd_pkg::*;
#(
  parameter int MAX_DIGITS = 5
) (
  input  wire         clk,
  input  wire         rst_n,
  // in_tdata: value[15:0]
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,
  // out_tdata: digit_0[3:0], digit_1[7:4], digit_2[11:8], digit_3[15:12],
  // digit_4[19:16], zero fill [23:20]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,
  // out_tuser: overflow[0]
  output logic [0:0]  out_tuser,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] MIN_N = 3'd2;

  // Configuration register.
  logic [CNT_W-1:0] digit_count_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_DIGIT_COUNT);
  assign cfg_prdata = (cfg_paddr[2] == REG_DIGIT_COUNT) ?
                      {29'd0, digit_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= 3'd5;
    end else if (cfg_wr) begin
      digit_count_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  // Effective count and overflow test are taken as the item enters, so
  // they travel with it down the pipeline.
  logic [CNT_W-1:0] eff_n;
  logic             ovf_in;
  work_t            entry_work;

  always_comb begin
    if (digit_count_r < MIN_N) begin
      eff_n = MIN_N;
    end else if (digit_count_r > MAX_N) begin
      eff_n = MAX_N;
    end else begin
      eff_n = digit_count_r;
    end
  end

  always_comb begin
    case (eff_n)
      3'd2:    ovf_in = in_tdata >= 16'd100;
      3'd3:    ovf_in = in_tdata >= 16'd1000;
      3'd4:    ovf_in = in_tdata >= 16'd10000;
      default: ovf_in = 1'b0;
    endcase
  end

  always_comb begin
    entry_work     = '0;
    entry_work.bin = in_tdata;
    entry_work.cnt = eff_n;
    entry_work.ovf = ovf_in;
  end

  // Double-dabble pipeline.
  logic  [NUM_STAGES:0] stg_valid;
  logic  [NUM_STAGES:0] stg_ready;
  work_t                stg_work [NUM_STAGES+1];

  assign stg_valid[0] = in_tvalid;
  assign in_tready    = stg_ready[0];
  assign stg_work[0]  = entry_work;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    b2bcd_dabble_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[g]),
      .up_ready (stg_ready[g]),
      .up_work  (stg_work[g]),
      .dn_valid (stg_valid[g+1]),
      .dn_ready (stg_ready[g+1]),
      .dn_work  (stg_work[g+1])
    );
  end

  // Formatting and output register.
  logic [OUT_DIGITS-1:0][DIGIT_W-1:0] out_digits;
  logic                               out_ovf;

  b2bcd_format u_format (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (stg_valid[NUM_STAGES]),
    .up_ready  (stg_ready[NUM_STAGES]),
    .up_work   (stg_work[NUM_STAGES]),
    .dn_valid  (out_tvalid),
    .dn_ready  (out_tready),
    .dn_digits (out_digits),
    .dn_ovf    (out_ovf)
  );

  assign out_tdata = {4'd0, out_digits};
  assign out_tuser = out_ovf;

  // An overflowing item shows nine in the top position.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[3:0] == DIGIT_NINE)
    else $error("overflow item without nine in the top position");

  // Overflow only happens with fewer than five positions, so the fifth is blank.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[19:16] == BLANK_CODE)
    else $error("overflow item with a used fifth position");

  // Once the top position shows a digit, blanking has ended.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] != BLANK_CODE |-> out_tdata[7:4] != BLANK_CODE)
    else $error("blank after a shown top digit");

endmodule
`default_nettype wire

/* hw/rtl/b2bcd_dabble_stage.sv */
// One pipeline stage that applies several double-dabble steps to an item.
`default_nettype none
module b2bcd_dabble_stage
  import b2bcd_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   up_valid,
  output logic  up_ready,
  input  work_t up_work,
  output logic  dn_valid,
  input  wire   dn_ready,
  output work_t dn_work
);

  logic  valid_r;
  work_t work_r;
  work_t work_nxt;

  always_comb begin
    work_nxt = up_work;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      work_nxt = dabble_step(work_nxt);
    end
  end

  // The stage takes a new item when it is empty or its item leaves now.
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      work_r <= work_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_work  = work_r;

endmodule
`default_nettype wire

/* hw/rtl/b2bcd_format.sv */
// Output stage: places digits by the display width, blanks leading zeros, shows nines on overflow.
`default_nettype none
module b2bcd_format
  import b2bcd_pkg::*;
(
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               up_valid,
  output logic                              up_ready,
  input  work_t                             up_work,
  output logic                              dn_valid,
  input  wire                               dn_ready,
  output logic [OUT_DIGITS-1:0][DIGIT_W-1:0] dn_digits,
  output logic                              dn_ovf
);

  logic                               valid_r;
  logic [OUT_DIGITS-1:0][DIGIT_W-1:0] digits_r;
  logic [OUT_DIGITS-1:0][DIGIT_W-1:0] digits_nxt;
  logic                               ovf_r;
  logic                               leading;
  logic [CNT_W-1:0]                   idx;
  logic [DIGIT_W-1:0]                 d;

  always_comb begin
    leading    = 1'b1;
    idx        = '0;
    d          = '0;
    digits_nxt = '0;
    for (int pos = 0; pos < OUT_DIGITS; pos++) begin
      idx = CNT_W'(up_work.cnt - 3'd1 - CNT_W'(pos));
      if (CNT_W'(pos) >= up_work.cnt) begin
        d = BLANK_CODE;
      end else if (up_work.ovf) begin
        d = DIGIT_NINE;
      end else begin
        d = up_work.bcd[{idx, 2'b00} +: DIGIT_W];
        if (leading && d == 4'd0 && CNT_W'(pos) < CNT_W'(up_work.cnt - 3'd1)) begin
          d = BLANK_CODE;
        end else begin
          leading = 1'b0;
        end
      end
      digits_nxt[pos] = d;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      digits_r <= digits_nxt;
      ovf_r    <= up_work.ovf;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_digits = digits_r;
  assign dn_ovf    = ovf_r;

endmodule
`default_nettype wire

/* tb/bcd_display_checker.sv */
// Checker for the blanked BCD converter: predicts each item's digits and compares results.
module bcd_display_checker
  import b2bcd_pkg::*;
#(
  parameter int MAX_DIGITS = 5
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [15:0] in_tdata,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [23:0] out_tdata,
  input  wire  [0:0]  out_tuser,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire         cfg_pready,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output int          mismatches,
  output int          outstanding
);

  localparam logic [CNT_W-1:0] DIGIT_COUNT_RESET = 3'd5;
  localparam logic [2:0]       DIGIT_COUNT_ADDR  = {REG_DIGIT_COUNT, 2'b00};

  typedef struct packed {
    logic [VALUE_W-1:0]                   value;
    logic [OUT_DIGITS-1:0][DIGIT_W-1:0]   digit;
    logic                                 ovf;
  } display_t;

  display_t         expected_displays[$];
  display_t         want;
  display_t         got;
  logic [CNT_W-1:0] digit_count;
  int               bad_fields = 0;

  function automatic void report(input string what, input int exp_val, input int act_val,
                                 input logic [VALUE_W-1:0] value);
    bad_fields++;
    $display("%0t: %s mismatch for value %0d: expected %0d, got %0d",
             $time, what, value, exp_val, act_val);
  endfunction

  // Decimal display of one value for the given digit count.
  function automatic display_t display_digits(input logic [VALUE_W-1:0] value,
                                              input logic [CNT_W-1:0] count);
    display_t r;
    int       used;
    int       scale;
    int       d;
    bit       leading;
    used = int'(count);
    if (used < 2) used = 2;
    if (used > MAX_DIGITS) used = MAX_DIGITS;
    if (used > OUT_DIGITS) used = OUT_DIGITS;
    scale = 1;
    repeat (used) scale = scale * 10;
    r.value = value;
    r.ovf   = (int'(value) >= scale);
    leading = 1'b1;
    for (int pos = 0; pos < OUT_DIGITS; pos++) begin
      if (pos >= used) begin
        r.digit[pos] = BLANK_CODE;
      end else if (r.ovf) begin
        r.digit[pos] = DIGIT_NINE;
      end else begin
        scale = scale / 10;
        d = (int'(value) / scale) % 10;
        if (leading && d == 0 && pos < used - 1) begin
          r.digit[pos] = BLANK_CODE;
        end else begin
          leading = 1'b0;
          r.digit[pos] = DIGIT_W'(d);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      digit_count = DIGIT_COUNT_RESET;
      expected_displays.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.value = '0;
        got.digit = out_tdata[BCD_W-1:0];
        got.ovf   = out_tuser[0];
        if (expected_displays.size() == 0) begin
          bad_fields++;
          $display("%0t: result with no item pending: tdata %h, tuser %b",
                   $time, out_tdata, out_tuser);
        end else begin
          want = expected_displays.pop_front();
          for (int k = 0; k < OUT_DIGITS; k++) begin
            if (got.digit[k] != want.digit[k]) begin
              report($sformatf("digit_%0d", k), want.digit[k], got.digit[k], want.value);
            end
          end
          if (got.ovf != want.ovf) report("overflow", want.ovf, got.ovf, want.value);
        end
      end
      // An item accepted at the same edge as a register write still sees the old count.
      if (in_tvalid && in_tready) begin
        expected_displays.push_back(display_digits(in_tdata, digit_count));
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == DIGIT_COUNT_ADDR) begin
        digit_count = cfg_pwdata[CNT_W-1:0];
      end
    end
    outstanding <= expected_displays.size();
    mismatches  <= bad_fields;
  end

endmodule

/* tb/tb_top.sv */
// Top of the blanked BCD converter testbench: clock, reset, stimulus and verdict.
module tb_top;
  import b2bcd_pkg::*;

  // The receiver's long hold-off, long enough to fill the five-stage pipeline
  // several times over while the sender keeps offering items.
  localparam int HOLD_OFF_CYCLES   = 80;
  localparam int ITEMS_PER_SETTING = 60;
  localparam int DRAIN_CYCLES      = 10;
  localparam logic [2:0] DIGIT_COUNT_ADDR = {REG_DIGIT_COUNT, 2'b00};

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  // in_tdata: value[15:0]
  logic [15:0] in_tdata    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  // out_tdata: digit_0[3:0], digit_1[7:4], digit_2[11:8], digit_3[15:12],
  // digit_4[19:16], zero fill [23:20]
  logic [23:0] out_tdata;
  // out_tuser: overflow[0]
  logic [0:0]  out_tuser;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int   mismatches;
  int   outstanding;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  // The stimulus counts hold-off requests up; the receiver tracks how many it has served.
  int   hold_off_reqs = 0;
  int   hold_off_seen = 0;

  // Digit count settings used by the random part. Every phase starts at a
  // different point of this list, so each setting meets every idling mix.
  // Zero, one, six and seven exercise the clamping at both ends.
  int count_plan [8] = '{5, 2, 7, 3, 0, 4, 1, 6};

  binary_to_bcd_blanked_unit #(.MAX_DIGITS(5)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  bcd_display_checker #(.MAX_DIGITS(5)) display_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver side. Normally it stalls at random with the current rate. When
  // the stimulus asks for a hold-off it drops tready and counts the stretch
  // out here, independent of the sender.
  always begin
    @(posedge clk);
    if (hold_off_seen != hold_off_reqs) begin
      hold_off_seen = hold_off_reqs;
      out_tready   <= 1'b0;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One register write: a setup cycle, then the access cycle held until
  // pready, after which the bus returns to idle.
  task automatic write_digit_count(input logic [CNT_W-1:0] count);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= DIGIT_COUNT_ADDR;
    cfg_pwdata  <= 32'(count);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Offers one item and returns at the edge that accepts it. Valid is left
  // high so back-to-back items need no extra cycle; random gaps lower it.
  task automatic send_value(input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops offering and waits until every accepted item has come back. The
  // first edge lets the checker's count catch up with the last acceptance.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Random values are weighted toward the decimal boundaries where digit
  // widths, blanking and overflow change, with full-range values to reach
  // every bit and a share of very small values for the zero blanking.
  function automatic logic [VALUE_W-1:0] pick_value();
    int scale;
    int v;
    scale = 10;
    repeat ($urandom_range(3)) scale = scale * 10;
    case ($urandom_range(3))
      0: v = $urandom_range(65535);
      1: v = scale + $urandom_range(4) - 2;
      2: v = (scale == 10000) ? $urandom_range(65535) : $urandom_range(scale * 10 - 1);
      default: v = $urandom_range(20);
    endcase
    return VALUE_W'(v);
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling on either side. Full width first: zero, the
    // digit boundaries, the largest value and alternating bit patterns.
    write_digit_count(3'd5);
    send_value(16'd0);
    send_value(16'd1);
    send_value(16'd9);
    send_value(16'd10);
    send_value(16'd99);
    send_value(16'd100);
    send_value(16'd1000);
    send_value(16'd9999);
    send_value(16'd10000);
    send_value(16'd10203);
    send_value(16'hFFFF);
    send_value(16'h5555);
    send_value(16'hAAAA);
    wait_drained();

    // Two digits: the overflow edge and zero in the shortest display.
    write_digit_count(3'd2);
    send_value(16'd0);
    send_value(16'd7);
    send_value(16'd99);
    send_value(16'd100);
    wait_drained();

    // Counts below range behave as two digits.
    write_digit_count(3'd0);
    send_value(16'd5);
    send_value(16'd100);
    wait_drained();
    write_digit_count(3'd1);
    send_value(16'd42);
    wait_drained();

    // Counts above range behave as five digits, so nothing can overflow.
    write_digit_count(3'd7);
    send_value(16'hFFFF);
    send_value(16'd0);
    wait_drained();
    write_digit_count(3'd6);
    send_value(16'd100);

    // Random part in three idling mixes, each across all digit counts.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 8; seg++) begin
        wait_drained();
        write_digit_count(CNT_W'(count_plan[(seg + phase) % 8]));
        // With the sender never idling, a long receiver hold-off backs the
        // pipeline up until the input stalls.
        if (phase == 2 && seg == 0) hold_off_reqs++;
        repeat (ITEMS_PER_SETTING) send_value(pick_value());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
